[sv/bfha_pkg.sv]
// Shared types and constants of the best-fit heap allocator.
// Holds status and opcode codes, datapath step codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package bfha_pkg;

  localparam int BYTE_W = 18;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_COAL  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_BAD_PTR  = 3'd3;
  localparam logic [2:0] ST_FREED    = 3'd4;

  localparam logic       CFG_HEAP  = 1'b0;
  localparam logic       CFG_SPLIT = 1'b1;
  localparam logic [12:0] HEAP_BYTES_RST = 13'd4096;
  localparam logic [12:0] MIN_SPLIT_RST  = 13'd8;

  typedef enum logic [4:0] {
    STEP_CLEAR, STEP_IDLE, STEP_DISP,
    STEP_A_CHK, STEP_A_RD, STEP_A_EV, STEP_A_BRD, STEP_A_BEV, STEP_A_W2, STEP_A_W3,
    STEP_SP_RD, STEP_SP_WR,
    STEP_F_CHK, STEP_F_EV, STEP_F_W2, STEP_F_NRD, STEP_F_NWR,
    STEP_C_RD, STEP_C_EV, STEP_C_NEV, STEP_C_W2,
    STEP_RESP
  } step_t;

  typedef struct packed {
    step_t      step;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] op;
    logic       a_bad;
    logic       pos_end;
    logic       bs_zero;
    logic       w_free;
    logic       exact;
    logic       have;
    logic       split;
    logic       tgt_in;
    logic       f_bad;
    logic       bs_ge4;
    logic       c_try;
    logic       c_merge;
    logic       out_busy;
  } stat_t;

endpackage
`default_nettype wire

[sv/bfha_ctrl.sv]
// Controller of the heap allocator: one-hot sequencer over the walks.
// Depends on bfha_pkg; drives the datapath through cmd_t, reads stat_t.
`default_nettype none
module bfha_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  bfha_pkg::stat_t    stat,
  output bfha_pkg::cmd_t     cmd
);
  import bfha_pkg::*;

  typedef enum logic [21:0] {
    S_CLEAR = 22'd1,      S_IDLE  = 22'd2,      S_DISP  = 22'd4,
    S_A_CHK = 22'd8,      S_A_RD  = 22'd16,     S_A_EV  = 22'd32,
    S_A_BRD = 22'd64,     S_A_BEV = 22'd128,    S_A_W2  = 22'd256,
    S_A_W3  = 22'd512,    S_SP_RD = 22'd1024,   S_SP_WR = 22'd2048,
    S_F_CHK = 22'd4096,   S_F_EV  = 22'd8192,   S_F_W2  = 22'd16384,
    S_F_NRD = 22'd32768,  S_F_NWR = 22'd65536,  S_C_RD  = 22'd131072,
    S_C_EV  = 22'd262144, S_C_NEV = 22'd524288, S_C_W2  = 22'd1048576,
    S_RESP  = 22'd2097152
  } state_t;

  state_t     state, state_next;
  logic [2:0] st, st_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.st = st;
    case (state)
      S_CLEAR: cmd.step = STEP_CLEAR;
      S_IDLE:  cmd.step = STEP_IDLE;
      S_DISP:  cmd.step = STEP_DISP;
      S_A_CHK: cmd.step = STEP_A_CHK;
      S_A_RD:  cmd.step = STEP_A_RD;
      S_A_EV:  cmd.step = STEP_A_EV;
      S_A_BRD: cmd.step = STEP_A_BRD;
      S_A_BEV: cmd.step = STEP_A_BEV;
      S_A_W2:  cmd.step = STEP_A_W2;
      S_A_W3:  cmd.step = STEP_A_W3;
      S_SP_RD: cmd.step = STEP_SP_RD;
      S_SP_WR: cmd.step = STEP_SP_WR;
      S_F_CHK: cmd.step = STEP_F_CHK;
      S_F_EV:  cmd.step = STEP_F_EV;
      S_F_W2:  cmd.step = STEP_F_W2;
      S_F_NRD: cmd.step = STEP_F_NRD;
      S_F_NWR: cmd.step = STEP_F_NWR;
      S_C_RD:  cmd.step = STEP_C_RD;
      S_C_EV:  cmd.step = STEP_C_EV;
      S_C_NEV: cmd.step = STEP_C_NEV;
      S_C_W2:  cmd.step = STEP_C_W2;
      S_RESP:  cmd.step = STEP_RESP;
      default: cmd.step = STEP_IDLE;
    endcase
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    case (state)
      S_CLEAR: if (stat.clear_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_DISP;
      S_DISP: begin
        case (stat.op)
          OP_ALLOC: state_next = S_A_CHK;
          OP_FREE:  state_next = S_F_CHK;
          OP_COAL:  state_next = S_C_RD;
          default: begin
            st_next    = ST_OK;
            state_next = S_RESP;
          end
        endcase
      end
      S_A_CHK: begin
        if (stat.a_bad) begin
          st_next    = ST_BAD_SIZE;
          state_next = S_RESP;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        if (!stat.pos_end) begin
          state_next = S_A_EV;
        end else if (stat.have) begin
          state_next = S_A_BRD;
        end else begin
          st_next    = ST_NO_FIT;
          state_next = S_RESP;
        end
      end
      S_A_EV: begin
        if (stat.bs_zero) begin
          if (stat.have) begin
            state_next = S_A_BRD;
          end else begin
            st_next    = ST_NO_FIT;
            state_next = S_RESP;
          end
        end else if (stat.exact) begin
          st_next    = ST_OK;
          state_next = S_SP_RD;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_BRD: state_next = S_A_BEV;
      S_A_BEV: begin
        st_next    = ST_OK;
        state_next = stat.split ? S_A_W2 : S_SP_RD;
      end
      S_A_W2:  state_next = S_A_W3;
      S_A_W3:  state_next = S_RESP;
      S_SP_RD: state_next = stat.tgt_in ? S_SP_WR : S_RESP;
      S_SP_WR: state_next = S_RESP;
      S_F_CHK: begin
        if (stat.f_bad) begin
          st_next    = ST_BAD_PTR;
          state_next = S_RESP;
        end else begin
          state_next = S_F_EV;
        end
      end
      S_F_EV: begin
        if (stat.w_free) begin
          st_next    = ST_FREED;
          state_next = S_RESP;
        end else begin
          st_next    = ST_OK;
          state_next = stat.bs_ge4 ? S_F_W2 : S_F_NRD;
        end
      end
      S_F_W2:  state_next = S_F_NRD;
      S_F_NRD: state_next = stat.tgt_in ? S_F_NWR : S_RESP;
      S_F_NWR: state_next = S_RESP;
      S_C_RD: begin
        if (stat.pos_end) begin
          st_next    = ST_OK;
          state_next = S_RESP;
        end else begin
          state_next = S_C_EV;
        end
      end
      S_C_EV: begin
        if (stat.bs_zero) begin
          st_next    = ST_OK;
          state_next = S_RESP;
        end else begin
          state_next = stat.c_try ? S_C_NEV : S_C_RD;
        end
      end
      S_C_NEV: state_next = stat.c_merge ? S_C_W2 : S_C_RD;
      S_C_W2:  state_next = S_C_RD;
      S_RESP:  if (!stat.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

endmodule
`default_nettype wire

[sv/bfha_datapath.sv]
// Datapath of the heap allocator: word store, walk registers, config and result.
// Depends on bfha_pkg; acts on cmd_t steps from bfha_ctrl and reports stat_t.
`default_nettype none
module bfha_datapath #(
  parameter int HEAP_BYTES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  bfha_pkg::cmd_t     cmd,
  output bfha_pkg::stat_t    stat,
  input  wire logic          in_valid,
  input  wire logic [1:0]    opcode,
  input  wire logic [15:0]   request_bytes,
  input  wire logic [15:0]   payload_offset,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         status,
  output logic [11:0]        result_offset,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_index,
  input  wire logic [12:0]   cfg_data
);
  import bfha_pkg::*;

  localparam int WORDS = HEAP_BYTES / 4;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CAP_I = (HEAP_BYTES / 8) * 8;
  localparam int E0_I  = (CAP_I < 4096) ? CAP_I : 4096;
  localparam logic [BYTE_W-1:0] CAP     = BYTE_W'(CAP_I);
  localparam logic [AW-1:0]     E0_LAST = AW'(E0_I / 4 - 1);
  localparam logic [AW-1:0]     CLR_END = AW'(WORDS - 1);

  logic [15:0]       mem [WORDS];
  logic [15:0]       rdata;
  logic [12:0]       heap_bytes_r, min_split_r;
  logic [1:0]        op_q;
  logic [15:0]       req_q, poff_q, wsv;
  logic [BYTE_W-1:0] pos, best, best_sz, tgt, rem, off_q;
  logic              have;
  logic [AW-1:0]     clr;

  logic [BYTE_W-1:0] lim, end_b, need, bs_rd, bs_sv, pos_bs, hdr, merged, rem_c;
  logic              rd_req, wr_req;
  logic [BYTE_W-1:0] rd_byte, wr_byte;
  logic [15:0]       wr_val, clr_val;

  assign lim    = {5'd0, heap_bytes_r[12:3], 3'd0};
  assign end_b  = (lim > CAP) ? CAP : lim;
  assign need   = (BYTE_W'(req_q) + BYTE_W'(11)) & ~BYTE_W'(7);
  assign bs_rd  = {2'd0, rdata[15:2], 2'd0};
  assign bs_sv  = {2'd0, wsv[15:2], 2'd0};
  assign pos_bs = pos + bs_rd;
  assign hdr    = BYTE_W'(poff_q) - BYTE_W'(4);
  assign merged = bs_sv + bs_rd;
  assign rem_c  = best_sz - need;

  always_comb begin
    stat.clear_done = (clr == CLR_END);
    stat.op         = op_q;
    stat.a_bad      = (req_q == 16'd0) || (need > end_b);
    stat.pos_end    = (pos >= end_b);
    stat.bs_zero    = (bs_rd == '0);
    stat.w_free     = !rdata[0];
    stat.exact      = !rdata[0] && (bs_rd == need);
    stat.have       = have;
    stat.split      = rem_c > BYTE_W'(min_split_r);
    stat.tgt_in     = (tgt < end_b);
    stat.f_bad      = (poff_q[2:0] != 3'd4) || (hdr >= end_b);
    stat.bs_ge4     = (bs_rd >= BYTE_W'(4));
    stat.c_try      = (pos_bs < end_b) && !rdata[0];
    stat.c_merge    = !rdata[0] && (bs_rd != '0) && (merged <= end_b - pos);
    stat.out_busy   = out_valid && !out_ready;
  end

  // at most one read and one write request per step
  always_comb begin
    rd_req  = 1'b0;
    rd_byte = pos;
    wr_req  = 1'b0;
    wr_byte = pos;
    wr_val  = rdata;
    case (cmd.step)
      STEP_A_RD: rd_req = !stat.pos_end;
      STEP_A_EV: begin
        wr_req = stat.exact;
        wr_val = rdata | 16'd1;
      end
      STEP_A_BRD: begin
        rd_req  = 1'b1;
        rd_byte = best;
      end
      STEP_A_BEV: begin
        wr_req = 1'b1;
        if (stat.split) begin
          wr_byte = best + need;
          wr_val  = rem_c[15:0] | 16'd2;
        end else begin
          wr_byte = best;
          wr_val  = rdata | 16'd1;
        end
      end
      STEP_A_W2: begin
        wr_req  = 1'b1;
        wr_byte = best + need + rem - BYTE_W'(4);
        wr_val  = rem[15:0];
      end
      STEP_A_W3: begin
        wr_req  = 1'b1;
        wr_byte = best;
        wr_val  = need[15:0] | 16'd1 | (wsv & 16'd2);
      end
      STEP_SP_RD, STEP_F_NRD: begin
        rd_req  = stat.tgt_in;
        rd_byte = tgt;
      end
      STEP_SP_WR: begin
        wr_req  = 1'b1;
        wr_byte = tgt;
        wr_val  = rdata | 16'd2;
      end
      STEP_F_CHK: begin
        rd_req  = !stat.f_bad;
        rd_byte = hdr;
      end
      STEP_F_EV: begin
        wr_req  = rdata[0];
        wr_byte = hdr;
        wr_val  = rdata & ~16'd1;
      end
      STEP_F_W2: begin
        wr_req  = 1'b1;
        wr_byte = hdr + bs_sv - BYTE_W'(4);
        wr_val  = bs_sv[15:0];
      end
      STEP_F_NWR: begin
        wr_req  = 1'b1;
        wr_byte = tgt;
        wr_val  = rdata & ~16'd2;
      end
      STEP_C_RD: rd_req = !stat.pos_end;
      STEP_C_EV: begin
        rd_req  = stat.c_try;
        rd_byte = pos_bs;
      end
      STEP_C_NEV: begin
        wr_req  = stat.c_merge;
        wr_byte = pos + merged - BYTE_W'(4);
        wr_val  = merged[15:0];
      end
      STEP_C_W2: begin
        wr_req = 1'b1;
        wr_val = rem[15:0] | (wsv & 16'd2);
      end
      default: begin
        rd_req = 1'b0;
        wr_req = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (clr == '0) begin
      clr_val = 16'(E0_I) | 16'd2;
    end else if (clr == E0_LAST) begin
      clr_val = 16'(E0_I);
    end else begin
      clr_val = 16'd0;
    end
  end

  // word store; writes at or past the limit are dropped
  always_ff @(posedge clk) begin
    if (cmd.step == STEP_CLEAR) begin
      mem[clr] <= clr_val;
    end else if (wr_req && (wr_byte < end_b)) begin
      mem[wr_byte[AW+1:2]] <= wr_val;
    end
    if (rd_req) begin
      rdata <= mem[rd_byte[AW+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr          <= '0;
      heap_bytes_r <= HEAP_BYTES_RST;
      min_split_r  <= MIN_SPLIT_RST;
      have         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if ((cmd.step == STEP_CLEAR) && !stat.clear_done) clr <= clr + AW'(1);
      if (cfg_valid) begin
        if (cfg_index == CFG_HEAP) heap_bytes_r <= cfg_data;
        else min_split_r <= cfg_data;
      end
      if ((cmd.step == STEP_IDLE) && in_valid) begin
        have <= 1'b0;
      end else if ((cmd.step == STEP_A_EV) && !stat.exact && !rdata[0] &&
                   (bs_rd > need) && (!have || (bs_rd < best_sz))) begin
        have <= 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((cmd.step == STEP_RESP) && !stat.out_busy) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_IDLE: begin
        if (in_valid) begin
          op_q   <= opcode;
          req_q  <= request_bytes;
          poff_q <= payload_offset;
          pos    <= '0;
        end
      end
      STEP_A_EV: begin
        if (stat.exact) begin
          tgt   <= pos_bs;
          off_q <= pos + BYTE_W'(4);
        end else if (!rdata[0] && (bs_rd > need) && (!have || (bs_rd < best_sz))) begin
          best    <= pos;
          best_sz <= bs_rd;
        end
        pos <= pos_bs;
      end
      STEP_A_BEV: begin
        wsv   <= rdata;
        rem   <= rem_c;
        off_q <= best + BYTE_W'(4);
        tgt   <= best + best_sz;
      end
      STEP_F_EV: begin
        wsv <= rdata & ~16'd1;
        tgt <= hdr + bs_rd;
      end
      STEP_C_EV: begin
        wsv <= rdata;
        tgt <= pos_bs;
        if (!stat.c_try) pos <= pos_bs;
      end
      STEP_C_NEV: begin
        rem <= merged;
        if (!stat.c_merge) pos <= tgt;
      end
      STEP_RESP: begin
        if (!stat.out_busy) begin
          status        <= cmd.st;
          result_offset <= ((op_q == OP_ALLOC) && (cmd.st == ST_OK)) ? off_q[11:0] : 12'd0;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/best_fit_heap_allocator_top.sv]
// Top level of the best-fit heap allocator.
// Depends on bfha_pkg, bfha_ctrl and bfha_datapath.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in      | in        | in_valid/in_ready   | opcode, request_bytes, payload_offset
//   out     | out       | out_valid/out_ready | status, result_offset
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request at a time. Allocate reads and evaluates each block header it
// walks, then does the split or header updates; coalesce walks the blocks
// likewise, reading the next header to try a merge; free rewrites the header,
// footer and next block's flag. The word store registers its read data.
// After reset a clearing pass writes every word of the initial heap;
// in_ready stays low during it, config writes are taken as ever.
// A waiting result holds in the output register; the next request is taken
// meanwhile and its own result waits until that transfer completes.
`default_nettype none
module best_fit_heap_allocator_top #(
  parameter int HEAP_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] request_bytes,
  input  wire logic [15:0] payload_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [11:0]      result_offset,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  import bfha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config registers never stall
  assign cfg_ready = 1'b1;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfha_datapath #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_valid       (in_valid),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .payload_offset (payload_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .result_offset  (result_offset),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule
`default_nettype wire

[sv/bfha_checker.sv]
// Port-level checks of the heap allocator, bound to the top level.
// Depends on bfha_pkg and best_fit_heap_allocator_top.
`default_nettype none
module bfha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [11:0] result_offset
);
  import bfha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_offset))
    else $error("result changed while stalled");

  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is at work");

  a_err_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> result_offset == 12'd0)
    else $error("offset given with an error status");

  a_align: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_offset != 12'd0) |-> result_offset[2:0] == 3'd4)
    else $error("payload offset not header plus 4 on an 8-byte block");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("channels active after reset");

endmodule

bind best_fit_heap_allocator_top bfha_checker u_chk (.*);
`default_nettype wire
